>>> rtl/timed_digital_output_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// timed digital output sequencer: assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TIMED_DIGITAL_OUTPUT_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_DIGITAL_OUTPUT_SEQUENCER_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TDOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TDOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tdos_pkg.sv
// ----------------------------------------------------------------------------
// tdos_pkg
// Widths, defaults, register indexes and the structs shared by the
// timed digital output sequencer modules.
// ----------------------------------------------------------------------------
package tdos_pkg;

    localparam int TS_W         = 64;
    localparam int LEN_W        = 16;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;

    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int TICKS_PER_MS_DEF = 10000;

    localparam logic [LEN_W-1:0] PULSE_LEN_RESET = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_LENGTH_MS = 8'd0,
        REG_MIXER_ENABLE    = 8'd1
    } cfg_reg_t;

    // request from the tick logic to the end-time queue
    typedef struct packed {
        logic            step;
        logic            start;
        logic            end_due;
        logic [TS_W-1:0] now;
        logic [TS_W-1:0] end_time;
    } q_req_t;

    // queue outcome for the current tick
    typedef struct packed {
        logic overflow;
        logic old_due;
        logic new_due;
    } q_status_t;

endpackage

>>> rtl/tdos_in_if.sv
// ----------------------------------------------------------------------------
// tdos_in_if
// Tick channel: timestamp and the three sampled digital inputs.
// ----------------------------------------------------------------------------
interface tdos_in_if;
    logic                      valid;
    logic                      ready;
    logic [tdos_pkg::TS_W-1:0] timestamp;
    logic                      control_voltage_ok;
    logic                      ejection_signal;
    logic                      clock_signal;

    modport source (
        output valid, timestamp, control_voltage_ok, ejection_signal, clock_signal,
        input  ready
    );
    modport sink (
        input  valid, timestamp, control_voltage_ok, ejection_signal, clock_signal,
        output ready
    );
endinterface

>>> rtl/tdos_out_if.sv
// ----------------------------------------------------------------------------
// tdos_out_if
// Result channel: output levels, counters and per-tick flags.
// ----------------------------------------------------------------------------
interface tdos_out_if;
    logic                       valid;
    logic                       ready;
    logic                       error_light;
    logic                       error_transfer;
    logic                       ejection_pulse;
    logic                       mixer_mode;
    logic [tdos_pkg::CNT_W-1:0] ejected_count;
    logic [tdos_pkg::TS_W-1:0]  clock_period;
    logic                       period_valid;
    logic                       queue_overflow;

    modport source (
        output valid, error_light, error_transfer, ejection_pulse, mixer_mode,
               ejected_count, clock_period, period_valid, queue_overflow,
        input  ready
    );
    modport sink (
        input  valid, error_light, error_transfer, ejection_pulse, mixer_mode,
               ejected_count, clock_period, period_valid, queue_overflow,
        output ready
    );
endinterface

>>> rtl/tdos_cfg_if.sv
// ----------------------------------------------------------------------------
// tdos_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tdos_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tdos_pkg::CFG_IDX_W-1:0]  index;
    logic [tdos_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/timed_digital_output_sequencer_top.sv
// ----------------------------------------------------------------------------
// timed_digital_output_sequencer_top
// Tick-driven digital output sequencer: voltage-loss error outputs, timed
// ejection pulses, ejection count, machine clock period and mixer mode.
// ----------------------------------------------------------------------------
// Usage
// tick: one word per time step, carrying the timestamp (100 ns units) and
//   the sampled control voltage, ejection and machine clock inputs.
// result: one word per tick with the output levels after that tick, the
//   ejection count, the last clock period and the per-tick flags.
// cfg: register writes (0 pulse length in ms, 1 mixer enable), always ready,
//   to be written only while no tick is in flight.
// From tick acceptance to result valid there is an input register, then
// the tick logic and end-time compares into the result register.
// One tick is taken per cycle while result is not stalled; the due check
// compares all QUEUE_DEPTH queued end times in parallel.
// When result is stalled the result register holds and the input register
// still takes one more tick; tick.ready then drops until result drains.
// Reset clears the queue, edge history, counters and period, sets the
// outputs to light off, transfer on, pulse off and restores register
// defaults (50 ms, mixer off). No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "timed_digital_output_sequencer_top_defines.svh"

module timed_digital_output_sequencer_top #(
    parameter int QUEUE_DEPTH  = tdos_pkg::QUEUE_DEPTH_DEF,
    parameter int TICKS_PER_MS = tdos_pkg::TICKS_PER_MS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tdos_in_if.sink    tick,
    tdos_out_if.source result,
    tdos_cfg_if.sink   cfg
);

    localparam int TS_W    = tdos_pkg::TS_W;
    localparam int CNT_W   = tdos_pkg::CNT_W;
    localparam int TICKS_W = tdos_pkg::LEN_W + $clog2(TICKS_PER_MS + 1);

    logic [TICKS_W-1:0] pulse_ticks;
    logic               mixer_enable;

    // input register
    logic            s1_valid_reg;
    logic [TS_W-1:0] s1_ts_reg;
    logic            s1_cv_reg;
    logic            s1_ej_reg;
    logic            s1_ck_reg;

    // sequencer state
    logic             prev_ej_reg;
    logic             prev_ck_reg;
    logic             armed_reg;
    logic             armed_next;
    logic [TS_W-1:0]  first_reg;
    logic [TS_W-1:0]  first_next;
    logic [TS_W-1:0]  period_reg;
    logic [TS_W-1:0]  period_next;
    logic             light_reg;
    logic             light_next;
    logic             transfer_reg;
    logic             transfer_next;
    logic             pulse_reg;
    logic             pulse_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic res_valid_reg;
    logic res_mixer_reg;
    logic res_pvalid_reg;
    logic res_pvalid_next;
    logic res_ovf_reg;

    logic                advance;
    logic                step;
    logic                start;
    logic                clk_edge;
    logic [TS_W:0]       end_sum;
    tdos_pkg::q_req_t    q_req;
    tdos_pkg::q_status_t q_status;

    tdos_cfg_regs #(
        .TICKS_PER_MS (TICKS_PER_MS),
        .TICKS_W      (TICKS_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pulse_ticks  (pulse_ticks),
        .mixer_enable (mixer_enable)
    );

    tdos_end_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (q_req),
        .status (q_status)
    );

    assign advance    = !res_valid_reg || result.ready;
    assign step       = s1_valid_reg && advance;
    assign tick.ready = !s1_valid_reg || advance;

    always_comb
    begin
        start    = s1_ej_reg && !prev_ej_reg;
        clk_edge = s1_ck_reg && !prev_ck_reg;

        // end time saturates at the top of the time range
        end_sum = {1'b0, s1_ts_reg} + (TS_W + 1)'(pulse_ticks);

        q_req.step     = step;
        q_req.start    = start;
        q_req.now      = s1_ts_reg;
        q_req.end_time = end_sum[TS_W] ? '1 : end_sum[TS_W-1:0];
        // the new end is due at once only for a zero length or a saturated now
        q_req.end_due  = (pulse_ticks == '0) || (&s1_ts_reg);

        light_next    = light_reg;
        transfer_next = transfer_reg;
        if (!s1_cv_reg && !light_reg)
        begin
            light_next    = 1'b1;
            transfer_next = 1'b0;
        end

        count_next = count_reg + CNT_W'(start);

        // older due ends cannot cancel a pulse that starts this tick
        if (start)
        begin
            pulse_next = !q_status.new_due;
        end
        else
        begin
            pulse_next = pulse_reg && !q_status.old_due;
        end

        armed_next      = armed_reg;
        first_next      = first_reg;
        period_next     = period_reg;
        res_pvalid_next = 1'b0;
        if (clk_edge)
        begin
            if (!armed_reg)
            begin
                first_next = s1_ts_reg;
                armed_next = 1'b1;
            end
            else
            begin
                period_next     = s1_ts_reg - first_reg;
                first_next      = '0;
                armed_next      = 1'b0;
                res_pvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            prev_ej_reg   <= 1'b0;
            prev_ck_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            first_reg     <= '0;
            period_reg    <= '0;
            light_reg     <= 1'b0;
            transfer_reg  <= 1'b1;
            pulse_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (tick.ready)
            begin
                s1_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
            if (step)
            begin
                prev_ej_reg  <= s1_ej_reg;
                prev_ck_reg  <= s1_ck_reg;
                armed_reg    <= armed_next;
                first_reg    <= first_next;
                period_reg   <= period_next;
                light_reg    <= light_next;
                transfer_reg <= transfer_next;
                pulse_reg    <= pulse_next;
                count_reg    <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_ts_reg <= tick.timestamp;
            s1_cv_reg <= tick.control_voltage_ok;
            s1_ej_reg <= tick.ejection_signal;
            s1_ck_reg <= tick.clock_signal;
        end
        if (step)
        begin
            res_mixer_reg  <= mixer_enable;
            res_pvalid_reg <= res_pvalid_next;
            res_ovf_reg    <= q_status.overflow;
        end
    end

    // level, count and period state is updated only on a step, so it
    // doubles as the result payload
    assign result.valid          = res_valid_reg;
    assign result.error_light    = light_reg;
    assign result.error_transfer = transfer_reg;
    assign result.ejection_pulse = pulse_reg;
    assign result.mixer_mode     = res_mixer_reg;
    assign result.ejected_count  = count_reg;
    assign result.clock_period   = period_reg;
    assign result.period_valid   = res_pvalid_reg;
    assign result.queue_overflow = res_ovf_reg;

    `TDOS_ASSERT_NEXT(a_light_latches, clk, rst_n,
        light_reg, light_reg,
        "error light went off after voltage loss")
    `TDOS_ASSERT_NOW(a_light_vs_transfer, clk, rst_n,
        light_reg, !transfer_reg,
        "error transfer still on with error light on")
    `TDOS_ASSERT_NEXT(a_period_disarms, clk, rst_n,
        step && res_pvalid_next, !armed_reg && first_reg == '0,
        "clock edge pair not reset after period update")

endmodule

>>> rtl/tdos_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdos_cfg_regs
// Configuration registers. The pulse length is kept already scaled to
// timestamp units so the tick path only has an add.
// ----------------------------------------------------------------------------
module tdos_cfg_regs #(
    parameter int TICKS_PER_MS = tdos_pkg::TICKS_PER_MS_DEF,
    parameter int TICKS_W      = tdos_pkg::LEN_W + $clog2(TICKS_PER_MS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    tdos_cfg_if.sink           cfg,
    output logic [TICKS_W-1:0] pulse_ticks,
    output logic               mixer_enable
);

    localparam logic [TICKS_W-1:0] TICKS_CONST  = TICKS_W'(TICKS_PER_MS);
    localparam logic [TICKS_W-1:0] TICKS_RESET  =
        TICKS_W'(tdos_pkg::PULSE_LEN_RESET) * TICKS_CONST;

    logic [TICKS_W-1:0] pulse_ticks_reg;
    logic [TICKS_W-1:0] pulse_ticks_next;
    logic               mixer_reg;
    logic               mixer_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        pulse_ticks_next = pulse_ticks_reg;
        mixer_next       = mixer_reg;
        if (cfg.valid)
        begin
            case (tdos_pkg::cfg_reg_t'(cfg.index))
                tdos_pkg::REG_PULSE_LENGTH_MS:
                begin
                    pulse_ticks_next = TICKS_W'(cfg.data[tdos_pkg::LEN_W-1:0]) * TICKS_CONST;
                end
                tdos_pkg::REG_MIXER_ENABLE:
                begin
                    mixer_next = cfg.data[0];
                end
                default:
                begin
                    // unknown index, write dropped
                    pulse_ticks_next = pulse_ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg <= TICKS_RESET;
            mixer_reg       <= 1'b0;
        end
        else
        begin
            pulse_ticks_reg <= pulse_ticks_next;
            mixer_reg       <= mixer_next;
        end
    end

    assign pulse_ticks  = pulse_ticks_reg;
    assign mixer_enable = mixer_reg;

endmodule

>>> rtl/tdos_end_queue.sv
// ----------------------------------------------------------------------------
// tdos_end_queue
// Pending pulse end times. Slots are tracked by an occupancy mask; every
// occupied slot is compared against the tick time in parallel.
// ----------------------------------------------------------------------------
`include "timed_digital_output_sequencer_top_defines.svh"

module tdos_end_queue #(
    parameter int QUEUE_DEPTH = tdos_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tdos_pkg::q_req_t    req,
    output tdos_pkg::q_status_t status
);

    logic [tdos_pkg::TS_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    occ_reg;
    logic [QUEUE_DEPTH-1:0]    occ_next;
    logic [QUEUE_DEPTH-1:0]    free;
    logic [QUEUE_DEPTH-1:0]    ins_slot;
    logic [QUEUE_DEPTH-1:0]    due;
    logic                      full;
    logic                      insert;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            due[i] = occ_reg[i] && (req.now >= slot_reg[i]);
        end
        free     = ~occ_reg;
        // lowest free slot
        ins_slot = free & (~free + QUEUE_DEPTH'(1));
        full     = &occ_reg;
        insert   = req.start && !full;
        occ_next = occ_reg & ~due;
        // an end that is already due never occupies a slot
        if (insert && !req.end_due)
        begin
            occ_next = occ_next | ins_slot;
        end
        status.overflow = req.start && full;
        status.old_due  = |due;
        status.new_due  = insert && req.end_due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (req.step)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (req.step && insert && ins_slot[i])
            begin
                slot_reg[i] <= req.end_time;
            end
        end
    end

    `TDOS_ASSERT_NEXT(a_no_grow_without_start, clk, rst_n,
        req.step && !req.start, (occ_reg & ~$past(occ_reg)) == '0,
        "queue gained an entry without an ejection start")
    `TDOS_ASSERT_NOW(a_overflow_only_when_full, clk, rst_n,
        status.overflow, occ_reg == '1,
        "end time dropped while a slot was free")
    `TDOS_ASSERT_NEXT(a_insert_leaves_entry, clk, rst_n,
        req.step && req.start && !full && !req.end_due, occ_reg != '0,
        "queued end time not held")

endmodule
